// ----- src/ctgl_pkg.sv -----
// ----------------------------------------------------------------------------
// ctgl_pkg: shared types, constants and arithmetic of the grid lookup
// Register indexes, stream word layout and the fixed-point blend step.
// ----------------------------------------------------------------------------
`default_nettype none

package ctgl_pkg;

    // Configuration register indexes
    localparam logic REG_GRID_SCALE    = 1'b0;
    localparam logic REG_LEVELS_IN_USE = 1'b1;

    // Input action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam int TDATA_W = 144;
    localparam int TUSER_W = 2;
    localparam int FRAC_W  = 17;

    // Fractions of the three axes, Q1.16 (one is representable)
    typedef struct packed {
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
        logic [FRAC_W-1:0] fz;
    } frac_t;

    // One linear blend, rounding half up:
    // floor((a*(1-f) + b*f + 0.5) / 1) written as a + (b-a)*f in Q.16.
    function automatic logic signed [31:0] blend(
        input logic signed [31:0] a,
        input logic signed [31:0] b,
        input logic [FRAC_W-1:0]  f
    );
        logic signed [32:0] diff;
        logic        [51:0] acc;
        diff = {b[31], b} - {a[31], a};
        acc  = 52'(diff * $signed({1'b0, f})) + {{4{a[31]}}, a, 16'd0} + 52'd32768;
        return acc[47:16];
    endfunction

endpackage

`default_nettype wire

// ----- src/ctgl_axis.sv -----
// ----------------------------------------------------------------------------
// ctgl_axis: splits one scaled coordinate into a clamped cell and fraction
// Also gives the half-grid indexes of the two parity banks on this axis.
// ----------------------------------------------------------------------------
`default_nettype none

module ctgl_axis #(
    parameter int SIZE = 16,
    parameter int CW   = 4,
    parameter int HW   = 3
) (
    input  wire logic signed [56:0]                p,
    output logic                                   parity,
    output logic [HW-1:0]                          idx_even,
    output logic [HW-1:0]                          idx_odd,
    output logic [ctgl_pkg::FRAC_W-1:0]            frac
);
    import ctgl_pkg::*;

    logic [25:0]   cell_raw;
    logic [CW-1:0] cell_idx;
    logic [CW:0]   cell_inc;

    // Integer part offset by half the grid, then clamped to the grid
    always_comb
    begin
        cell_raw = {p[56], p[56:32]} + 26'(SIZE / 2);
        if (cell_raw[25])
        begin
            cell_idx = '0;
            frac     = '0;
        end
        else if (cell_raw > 26'(SIZE - 2))
        begin
            cell_idx = CW'(SIZE - 2);
            frac     = FRAC_W'(65536);
        end
        else
        begin
            cell_idx = cell_raw[CW-1:0];
            frac     = {1'b0, p[31:16]};
        end
        cell_inc = {1'b0, cell_idx} + 1'b1;
        parity   = cell_idx[0];
        idx_odd  = HW'(cell_idx >> 1);
        idx_even = HW'(cell_inc >> 1);
    end

endmodule

`default_nettype wire

// ----- src/ctgl_banks.sv -----
// ----------------------------------------------------------------------------
// ctgl_banks: eight grid banks split by the parity of x, y and z
// Each bank has one write and one registered read per cycle while en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ctgl_banks #(
    parameter int AW = 12
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic          we,
    input  wire logic [2:0]    wbank,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic [AW-1:0] raddr [8],
    output logic      [31:0]   rdata [8]
);
    import ctgl_pkg::*;

    for (genvar b = 0; b < 8; b++)
    begin : g_bank
        logic [31:0] mem [2**AW];

        // Write one word or read one corner; the pipeline stall holds both
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (we && (wbank == 3'(b)))
                begin
                    mem[waddr] <= wdata;
                end
                rdata[b] <= mem[raddr[b]];
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/ctgl_blend.sv -----
// ----------------------------------------------------------------------------
// ctgl_blend: three-stage trilinear blend of the eight corner words
// Blends along x, then y, then z, one multiplier level per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ctgl_blend (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 valid_in,
    input  wire logic [2:0]           parity,
    input  wire ctgl_pkg::frac_t      fr,
    input  wire logic [31:0]          rdata [8],
    output logic                      valid_out,
    output logic [31:0]               potential
);
    import ctgl_pkg::*;

    logic signed [31:0] corner [8];
    logic signed [31:0] row_reg [4];
    logic signed [31:0] row_next [4];
    logic signed [31:0] plane_reg [2];
    logic [FRAC_W-1:0]  fy_reg, fz3_reg, fz4_reg;
    logic               v3_reg, v4_reg, v5_reg;
    logic [31:0]        pot_reg;

    // Corner {dz,dy,dx} sits in the bank of parity base ^ offset
    always_comb
    begin
        for (int d = 0; d < 8; d++)
        begin
            corner[d] = $signed(rdata[3'(d) ^ parity]);
        end
        for (int r = 0; r < 4; r++)
        begin
            row_next[r] = blend(corner[2 * r], corner[2 * r + 1], fr.fx);
        end
    end

    // Valid bits of the blend stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= valid_in;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Blend data path
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_reg      <= row_next;
            fy_reg       <= fr.fy;
            fz3_reg      <= fr.fz;
            plane_reg[0] <= blend(row_reg[0], row_reg[1], fy_reg);
            plane_reg[1] <= blend(row_reg[2], row_reg[3], fy_reg);
            fz4_reg      <= fz3_reg;
            pot_reg      <= blend(plane_reg[0], plane_reg[1], fz4_reg);
        end
    end

    assign valid_out = v5_reg;
    assign potential = pot_reg;

endmodule

`default_nettype wire

// ----- src/clamped_trilinear_grid_lookup.sv -----
// ----------------------------------------------------------------------------
// clamped_trilinear_grid_lookup: banked potential grid with trilinear lookup
//
// Words arrive on the s_ stream. tuser carries the action (load or query)
// and the species; tdata carries level, position and load fields. A load
// word writes one grid sample and gives no result. A query word scales its
// position, clamps the cell to the grid and returns the interpolated
// potential on the m_ stream.
// The grid is split into eight banks by the parity of x, y and z, so all
// eight corners of a cell are read in the same cycle. The pipeline takes
// one word per cycle; when the receiver stalls, the whole pipeline holds
// and s_tready falls only while a finished result waits in the output
// register. A query result passes the input, scaling, bank-read, row,
// plane and output registers. A load takes effect for every word accepted
// after it. Reset clears the valid bits and the registers (grid_scale = 1.0,
// levels_in_use = 3); the grid contents are undefined until loaded.
// Configuration is written through cfg_we / cfg_addr / cfg_data while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module clamped_trilinear_grid_lookup #(
    parameter int SIZE_X = 16,
    parameter int SIZE_Y = 16,
    parameter int SIZE_Z = 16,
    parameter int LEVELS = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_addr,
    input  wire logic [23:0]                   cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // level, pos_x, pos_y, pos_z, load_x, load_y, load_z, load_value
    input  wire logic [ctgl_pkg::TDATA_W-1:0]  s_tdata,
    // action, species
    input  wire logic [ctgl_pkg::TUSER_W-1:0]  s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // potential
    output logic [31:0]                        m_tdata
);
    import ctgl_pkg::*;

    localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CXW = $clog2(SIZE_X);
    localparam int CYW = $clog2(SIZE_Y);
    localparam int CZW = $clog2(SIZE_Z);
    localparam int HXW = ($clog2((SIZE_X + 1) / 2) > 0) ? $clog2((SIZE_X + 1) / 2) : 1;
    localparam int HYW = ($clog2((SIZE_Y + 1) / 2) > 0) ? $clog2((SIZE_Y + 1) / 2) : 1;
    localparam int HZW = ($clog2((SIZE_Z + 1) / 2) > 0) ? $clog2((SIZE_Z + 1) / 2) : 1;
    localparam int AW  = 1 + LW + HXW + HYW + HZW;

    logic [23:0] grid_scale_reg;
    logic [1:0]  levels_reg;

    logic               en;
    logic               v0_reg, act0_reg, sp0_reg;
    logic [2:0]         lv0_reg;
    logic signed [31:0] pos0_reg [3];
    logic [3:0]         lx0_reg, ly0_reg, lz0_reg;
    logic [31:0]        val0_reg;

    logic               v1_reg, act1_reg, sp1_reg;
    logic [2:0]         lv1_reg;
    logic signed [56:0] p1_reg [3];
    logic [3:0]         lx1_reg, ly1_reg, lz1_reg;
    logic [31:0]        val1_reg;

    logic               q2_reg;
    logic [2:0]         par2_reg;
    frac_t              fr2_reg;

    logic [2:0]         parity;
    frac_t              fr;
    logic [HXW-1:0]     ix_even, ix_odd;
    logic [HYW-1:0]     iy_even, iy_odd;
    logic [HZW-1:0]     iz_even, iz_odd;
    logic [2:0]         lv_clamp;
    logic [LW-1:0]      lv_query;
    logic               load_ok;
    logic [AW-1:0]      raddr [8];
    logic [AW-1:0]      waddr;
    logic [31:0]        rdata [8];
    logic               blend_valid;

    // The pipeline moves unless a result waits for the receiver
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_scale_reg <= 24'd65536;
            levels_reg     <= 2'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_GRID_SCALE:    grid_scale_reg <= cfg_data;
                REG_LEVELS_IN_USE: levels_reg     <= cfg_data[1:0];
                default:           ;
            endcase
        end
    end

    // Valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            q2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
            q2_reg <= v1_reg && (act1_reg == ACT_QUERY);
        end
    end

    // Input register, position scaling and the registered cell parity and fractions
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            act0_reg    <= s_tuser[0];
            sp0_reg     <= s_tuser[1];
            lv0_reg     <= s_tdata[2:0];
            pos0_reg[0] <= s_tdata[34:3];
            pos0_reg[1] <= s_tdata[66:35];
            pos0_reg[2] <= s_tdata[98:67];
            lx0_reg     <= s_tdata[102:99];
            ly0_reg     <= s_tdata[106:103];
            lz0_reg     <= s_tdata[110:107];
            val0_reg    <= s_tdata[142:111];

            act1_reg    <= act0_reg;
            sp1_reg     <= sp0_reg;
            lv1_reg     <= lv0_reg;
            for (int a = 0; a < 3; a++)
            begin
                p1_reg[a] <= 57'(pos0_reg[a] * $signed({1'b0, grid_scale_reg}));
            end
            lx1_reg     <= lx0_reg;
            ly1_reg     <= ly0_reg;
            lz1_reg     <= lz0_reg;
            val1_reg    <= val0_reg;

            par2_reg    <= parity;
            fr2_reg     <= fr;
        end
    end

    ctgl_axis #(.SIZE(SIZE_X), .CW(CXW), .HW(HXW)) u_axis_x (
        .p(p1_reg[0]), .parity(parity[0]), .idx_even(ix_even), .idx_odd(ix_odd),
        .frac(fr.fx)
    );
    ctgl_axis #(.SIZE(SIZE_Y), .CW(CYW), .HW(HYW)) u_axis_y (
        .p(p1_reg[1]), .parity(parity[1]), .idx_even(iy_even), .idx_odd(iy_odd),
        .frac(fr.fy)
    );
    ctgl_axis #(.SIZE(SIZE_Z), .CW(CZW), .HW(HZW)) u_axis_z (
        .p(p1_reg[2]), .parity(parity[2]), .idx_even(iz_even), .idx_odd(iz_odd),
        .frac(fr.fz)
    );

    // Level clamp, load range check and bank addresses
    always_comb
    begin
        lv_clamp = (lv1_reg > {1'b0, levels_reg}) ? {1'b0, levels_reg} : lv1_reg;
        if ({2'b00, lv_clamp} >= 5'(LEVELS))
        begin
            lv_query = LW'(LEVELS - 1);
        end
        else
        begin
            lv_query = LW'(lv_clamp);
        end
        load_ok = ({2'b00, lv1_reg} < 5'(LEVELS)) && ({5'd0, lx1_reg} < 9'(SIZE_X))
               && ({5'd0, ly1_reg} < 9'(SIZE_Y)) && ({5'd0, lz1_reg} < 9'(SIZE_Z));
        for (int b = 0; b < 8; b++)
        begin
            raddr[b] = {sp1_reg, lv_query,
                        (b[0] ? ix_odd : ix_even),
                        (b[1] ? iy_odd : iy_even),
                        (b[2] ? iz_odd : iz_even)};
        end
        waddr = {sp1_reg, LW'(lv1_reg), HXW'(lx1_reg >> 1), HYW'(ly1_reg >> 1),
                 HZW'(lz1_reg >> 1)};
    end

    ctgl_banks #(.AW(AW)) u_banks (
        .clk   (clk),
        .en    (en),
        .we    (v1_reg && (act1_reg == ACT_LOAD) && load_ok),
        .wbank ({lz1_reg[0], ly1_reg[0], lx1_reg[0]}),
        .waddr (waddr),
        .wdata (val1_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    ctgl_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (q2_reg),
        .parity    (par2_reg),
        .fr        (fr2_reg),
        .rdata     (rdata),
        .valid_out (blend_valid),
        .potential (m_tdata)
    );

    assign m_tvalid = blend_valid;

endmodule

`default_nettype wire

// ----- src/ctgl_checker.sv -----
// ----------------------------------------------------------------------------
// ctgl_checker: port-level checks of the grid lookup
// Watches the stream handshakes over time.
// ----------------------------------------------------------------------------
`default_nettype none

module ctgl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // No result is shown while reset is held
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result shown during reset");

    // A receiver that takes words never blocks the input side
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    // The input side stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a waiting result");

    // A stalled result holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind clamped_trilinear_grid_lookup ctgl_checker u_ctgl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
